// File: rtl/lrf_pkg.sv
// ----------------------------------------------------------------------------
// lrf_pkg
// shared types, codes and the crc helper for the log record framer
// ----------------------------------------------------------------------------
package lrf_pkg;

    // widths of the stored counters and registers
    localparam int SEGMENT_SIZE_BITS = 40;
    localparam int LEN_W             = 32;
    localparam int CRC_W             = 32;
    localparam int AGE_W             = 32;
    localparam int MAX_BYTES_W       = 40;
    localparam int MAX_AGE_W         = 32;
    localparam int BYTE_W            = 8;

    // configuration port
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 40;
    localparam logic [CFG_ADDR_W-1:0] CFG_FRAMED_MODE = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_MAX_BYTES   = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_MAX_AGE     = 2'd2;

    // stream payload widths
    localparam int S_TDATA_W = 8;
    localparam int KIND_W    = 2;
    localparam int M_FIELD_W = BYTE_W + 1 + LEN_W + CRC_W;
    localparam int M_TDATA_W = ((M_FIELD_W + 7) / 8) * 8;
    localparam int M_PAD_W   = M_TDATA_W - M_FIELD_W;

    // segment size arithmetic
    localparam int ADD_W     = LEN_W + 1;
    localparam int SEG_CMP_W = (SEGMENT_SIZE_BITS > MAX_BYTES_W) ?
                               SEGMENT_SIZE_BITS : MAX_BYTES_W;
    localparam int SEG_SUM_W = ((SEGMENT_SIZE_BITS > ADD_W) ?
                                SEGMENT_SIZE_BITS : ADD_W) + 1;
    localparam logic [SEGMENT_SIZE_BITS-1:0] SEG_MASK = {SEGMENT_SIZE_BITS{1'b1}};
    localparam logic [3:0] FRAME_OVERHEAD = 4'd8;

    localparam logic [CRC_W-1:0]  CRC_POLY = 32'hEDB8_8320;
    localparam logic [CRC_W-1:0]  CRC_INIT = 32'hFFFF_FFFF;
    localparam logic [BYTE_W-1:0] NEWLINE  = 8'h0A;

    typedef enum logic [KIND_W-1:0] {
        KIND_BYTE   = 2'd0,
        KIND_TICK   = 2'd1,
        KIND_ROTATE = 2'd2,
        KIND_EMPTY  = 2'd3
    } in_kind_t;

    typedef enum logic [KIND_W-1:0] {
        OUT_BYTE    = 2'd0,
        OUT_TRAILER = 2'd1,
        OUT_ROTATED = 2'd2
    } out_kind_t;

    typedef enum logic [1:0] {
        PH_FIRST   = 2'd0,
        PH_NEWLINE = 2'd1,
        PH_TRAILER = 2'd2
    } phase_t;

    // reflected crc-32 over one byte, unrolled into an xor network
    function automatic logic [CRC_W-1:0] crc_update(logic [CRC_W-1:0] crc,
                                                    logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] c;
        c = crc ^ {{(CRC_W-BYTE_W){1'b0}}, b};
        for (int k = 0; k < BYTE_W; k++)
        begin
            c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// File: rtl/log_record_framer_with_rotation.sv
// ----------------------------------------------------------------------------
// log_record_framer_with_rotation
// passes log record bytes, appends a missing newline, closes each record with
// a length and crc-32 trailer, and flags segment rotation on size or age
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake        | payload
//  ---------+-----------+------------------+------------------------------------
//  s_*      | in        | s_tvalid/tready  | tuser kind, tdata byte, tlast final
//  m_*      | out       | m_tvalid/tready  | tuser out kind, tdata result, tlast
//  cfg_*    | in        | cfg_we           | cfg_addr index, cfg_wdata value
//
//  an input word sits in the item register and a sequencer emits one result
//  word per cycle into the output register while the output slot is free:
//  none for a tick, one for a non-final byte or a forced rotation, two for
//  an empty record, two or three for a final byte (extra newline, then trailer)
//  the crc advances one byte per unstalled cycle in an unrolled xor network
//  s_tready stays high while the current item finishes in the same cycle,
//  so single-result items stream at one word per clock while m_tready holds
//  rst_n clears control, counters, configuration and the item register;
//  the output payload is not reset; no clearing pass
//
module log_record_framer_with_rotation
    import lrf_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // [7:0] data_byte
    input  logic [KIND_W-1:0]     s_tuser,   // [1:0] kind
    input  logic                  s_tlast,   // final_byte

    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [7:0] out_byte, [8] rotate_before, [40:9] record_length,
    // [72:41] record_crc, upper bits zero
    output logic [M_TDATA_W-1:0]  m_tdata,
    output logic [KIND_W-1:0]     m_tuser,   // [1:0] out_kind
    output logic                  m_tlast,   // end_of_run

    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    // configuration
    logic                         framed_mode_reg;
    logic [MAX_BYTES_W-1:0]       max_bytes_reg;
    logic [MAX_AGE_W-1:0]         max_age_reg;

    // item register
    logic                         item_valid_reg, item_valid_next;
    in_kind_t                     item_kind_reg;
    logic [BYTE_W-1:0]            item_byte_reg;
    logic                         item_last_reg;
    phase_t                       phase_reg, phase_next;

    // record and segment state
    logic                         in_record_reg, in_record_next;
    logic [LEN_W-1:0]             length_reg, length_next;
    logic [CRC_W-1:0]             crc_reg, crc_next;
    logic [SEGMENT_SIZE_BITS-1:0] seg_bytes_reg, seg_bytes_next;
    logic [AGE_W-1:0]             seg_age_reg, seg_age_next;

    // output register
    logic                         out_valid_reg, out_valid_next;
    out_kind_t                    out_kind_reg, out_kind_next;
    logic [BYTE_W-1:0]            out_byte_reg, out_byte_next;
    logic                         out_rot_reg, out_rot_next;
    logic [LEN_W-1:0]             out_len_reg, out_len_next;
    logic [CRC_W-1:0]             out_crc_reg, out_crc_next;
    logic                         out_last_reg;

    logic                         out_free;
    logic                         needs_out;
    logic                         step;
    logic                         last_phase;
    logic                         item_done;
    logic                         accept;
    logic                         emit;
    logic                         limit_hit;
    logic                         open_rot;
    logic [ADD_W-1:0]             seg_add;
    logic [SEG_SUM_W-1:0]         seg_sum;
    logic [SEGMENT_SIZE_BITS-1:0] seg_closed;

    // ---------------------------------------------------------------- control
    // output slot frees up when empty or being taken this cycle
    assign out_free  = !out_valid_reg || m_tready;
    // a tick produces no word, so it never waits on the output side
    assign needs_out = !(phase_reg == PH_FIRST && item_kind_reg == KIND_TICK);
    assign step      = item_valid_reg && (out_free || !needs_out);
    assign item_done = step && last_phase;
    assign s_tready  = !item_valid_reg || item_done;
    assign accept    = s_tvalid && s_tready;

    // rotation check, made only when a record opens
    assign limit_hit =
        ((max_bytes_reg != '0) &&
         (SEG_CMP_W'(seg_bytes_reg) >= SEG_CMP_W'(max_bytes_reg))) ||
        ((max_age_reg != '0) && (seg_age_reg >= max_age_reg));
    assign open_rot  = !in_record_reg && limit_hit;

    // segment size after a record closes, saturating at the top
    assign seg_add    = ADD_W'(length_reg) +
                        (framed_mode_reg ? ADD_W'(FRAME_OVERHEAD) : ADD_W'(0));
    assign seg_sum    = SEG_SUM_W'(seg_bytes_reg) + SEG_SUM_W'(seg_add);
    assign seg_closed = (seg_sum > SEG_SUM_W'(SEG_MASK)) ?
                        SEG_MASK : seg_sum[SEGMENT_SIZE_BITS-1:0];

    // sequencer next phase
    always_comb
    begin
        phase_next = phase_reg;
        last_phase = 1'b0;
        unique case (phase_reg)
            PH_FIRST:
            begin
                unique case (item_kind_reg)
                    KIND_BYTE:
                    begin
                        if (item_last_reg)
                        begin
                            // a final newline skips the appended one
                            phase_next = (item_byte_reg != NEWLINE) ?
                                         PH_NEWLINE : PH_TRAILER;
                        end
                        else
                        begin
                            last_phase = 1'b1;
                        end
                    end
                    KIND_EMPTY:  phase_next = PH_TRAILER;
                    KIND_TICK:   last_phase = 1'b1;
                    KIND_ROTATE: last_phase = 1'b1;
                endcase
            end
            PH_NEWLINE: phase_next = PH_TRAILER;
            PH_TRAILER: last_phase = 1'b1;
            default:    last_phase = 1'b1;
        endcase
        if (last_phase)
        begin
            phase_next = PH_FIRST;
        end
    end

    // per-phase result word and state update
    always_comb
    begin
        emit           = 1'b0;
        out_kind_next  = OUT_BYTE;
        out_byte_next  = '0;
        out_rot_next   = 1'b0;
        out_len_next   = '0;
        out_crc_next   = '0;
        in_record_next = in_record_reg;
        length_next    = length_reg;
        crc_next       = crc_reg;
        seg_bytes_next = seg_bytes_reg;
        seg_age_next   = seg_age_reg;
        unique case (phase_reg)
            PH_FIRST:
            begin
                unique case (item_kind_reg)
                    KIND_TICK:
                    begin
                        if (seg_age_reg != {AGE_W{1'b1}})
                        begin
                            seg_age_next = seg_age_reg + AGE_W'(1);
                        end
                    end
                    KIND_ROTATE:
                    begin
                        emit           = 1'b1;
                        out_kind_next  = OUT_ROTATED;
                        seg_bytes_next = '0;
                        seg_age_next   = '0;
                    end
                    KIND_BYTE, KIND_EMPTY:
                    begin
                        // crc and length already sit at their start values
                        // whenever no record is open
                        emit           = 1'b1;
                        out_byte_next  = (item_kind_reg == KIND_BYTE) ?
                                         item_byte_reg : NEWLINE;
                        out_rot_next   = open_rot;
                        in_record_next = 1'b1;
                        crc_next       = crc_update(crc_reg, out_byte_next);
                        length_next    = length_reg + LEN_W'(1);
                        if (open_rot)
                        begin
                            seg_bytes_next = '0;
                            seg_age_next   = '0;
                        end
                    end
                endcase
            end
            PH_NEWLINE:
            begin
                emit          = 1'b1;
                out_byte_next = NEWLINE;
                crc_next      = crc_update(crc_reg, NEWLINE);
                length_next   = length_reg + LEN_W'(1);
            end
            PH_TRAILER:
            begin
                emit           = 1'b1;
                out_kind_next  = OUT_TRAILER;
                out_len_next   = length_reg;
                out_crc_next   = crc_reg ^ CRC_INIT;
                seg_bytes_next = seg_closed;
                in_record_next = 1'b0;
                length_next    = '0;
                crc_next       = CRC_INIT;
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    assign item_valid_next = accept ? 1'b1 : (item_done ? 1'b0 : item_valid_reg);
    assign out_valid_next  = (step && emit) ? 1'b1 :
                             (m_tready ? 1'b0 : out_valid_reg);

    // -------------------------------------------------------------- registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            framed_mode_reg <= 1'b0;
            max_bytes_reg   <= '0;
            max_age_reg     <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_FRAMED_MODE: framed_mode_reg <= cfg_wdata[0];
                CFG_MAX_BYTES:   max_bytes_reg   <= cfg_wdata[MAX_BYTES_W-1:0];
                CFG_MAX_AGE:     max_age_reg     <= cfg_wdata[MAX_AGE_W-1:0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            phase_reg      <= PH_FIRST;
            in_record_reg  <= 1'b0;
            length_reg     <= '0;
            crc_reg        <= CRC_INIT;
            seg_bytes_reg  <= '0;
            seg_age_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            out_valid_reg  <= out_valid_next;
            if (step)
            begin
                phase_reg     <= phase_next;
                in_record_reg <= in_record_next;
                length_reg    <= length_next;
                crc_reg       <= crc_next;
                seg_bytes_reg <= seg_bytes_next;
                seg_age_reg   <= seg_age_next;
            end
        end
    end

    // item payload, reset so the sequencer never decodes an unknown kind
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_kind_reg <= KIND_BYTE;
            item_byte_reg <= '0;
            item_last_reg <= 1'b0;
        end
        else if (accept)
        begin
            item_kind_reg <= in_kind_t'(s_tuser);
            item_byte_reg <= s_tdata[BYTE_W-1:0];
            item_last_reg <= s_tlast;
        end
    end

    // output payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (step && emit)
        begin
            out_kind_reg <= out_kind_next;
            out_byte_reg <= out_byte_next;
            out_rot_reg  <= out_rot_next;
            out_len_reg  <= out_len_next;
            out_crc_reg  <= out_crc_next;
            out_last_reg <= last_phase;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {{M_PAD_W{1'b0}}, out_crc_reg, out_len_reg, out_rot_reg,
                       out_byte_reg};

`ifndef SYNTHESIS
    // a closed record always leaves crc and length at their start values
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_record_reg |-> (crc_reg == CRC_INIT) && (length_reg == '0))
        else $error("crc or length not reset outside a record");

    // the newline and trailer phases only run inside an open record
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != PH_FIRST) |-> item_valid_reg && in_record_reg)
        else $error("sequencer past first phase without an open record");

    // a trailer always ends the run of its input
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_kind_reg == OUT_TRAILER) |-> out_last_reg)
        else $error("trailer word without end of run");

    // rotation is only flagged on a record byte
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_rot_reg |-> (out_kind_reg == OUT_BYTE))
        else $error("rotate flag on a non-byte word");

    // issuing a trailer closes the record
    assert property (@(posedge clk) disable iff (!rst_n)
        step && (phase_reg == PH_TRAILER) |=> !in_record_reg)
        else $error("record still open after its trailer");
`endif

endmodule

// File: tb/sv/log_record_framer_with_rotation_tb.sv
// ----------------------------------------------------------------------------
// log_record_framer_with_rotation_tb
// self-checking bench for the log record framer: a queue-fed stream driver, a
// framing predictor with its own crc-32 and segment counters, and a monitor
// that checks every output word field by field under several idling phases
// ----------------------------------------------------------------------------
module log_record_framer_with_rotation_tb;

    import lrf_pkg::*;

    // cycles the block may still be busy after the last expected word
    localparam int DRAIN_CYCLES  = 4;
    // cycles with no word accepted on either side before the run is abandoned
    localparam int QUIET_LIMIT   = 3000;
    // length of the one long receiver hold-off
    localparam int LONG_STALL    = 300;

    // one input word for the driver
    typedef struct packed {
        in_kind_t         kind;
        logic [7:0]       data;
        logic             fin;
    } log_item_t;

    // one output word the framer must produce
    typedef struct packed {
        out_kind_t        kind;
        logic [7:0]       data;
        logic             rot;
        logic [31:0]      len;
        logic [31:0]      crc;
        logic             last;
    } frame_word_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;

    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;         // [7:0] data_byte
    logic [KIND_W-1:0]     s_tuser   = KIND_BYTE;  // [1:0] kind
    logic                  s_tlast   = 1'b0;       // final_byte

    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    // [7:0] out_byte, [8] rotate_before, [40:9] record_length,
    // [72:41] record_crc, upper bits zero
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [KIND_W-1:0]     m_tuser;                // [1:0] out_kind
    logic                  m_tlast;                // end_of_run

    logic                  cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // stimulus and expectation stores
    log_item_t   log_items_q [$];
    frame_word_t words_due [$];
    log_item_t   drv_item;
    frame_word_t due_word;

    // idling knobs; the sequence sets the percentages and long_stall_req at falling edges
    int          src_idle_pct    = 0;
    int          sink_stall_pct  = 0;
    logic        long_stall_req  = 1'b0;
    logic        long_stall_done = 1'b0;
    int          stall_left      = 0;

    int          errors          = 0;
    int          quiet_cycles    = 0;

    // predictor copy of the registers
    logic        cfg_framed      = 1'b0;
    logic [39:0] cfg_max_size    = '0;
    logic [31:0] cfg_max_age     = '0;

    // predictor copy of the record and segment state
    logic        rec_open        = 1'b0;
    logic [31:0] rec_len         = '0;
    logic [31:0] rec_crc         = '1;
    logic [39:0] seg_size        = '0;
    logic [31:0] seg_age         = '0;

    always #5 clk = ~clk;

    log_record_framer_with_rotation uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    // ------------------------------------------------------------------------
    // framing predictor
    // ------------------------------------------------------------------------

    // reflected crc-32, one bit at a time
    function automatic logic [31:0] crc_step(logic [31:0] c, logic [7:0] b);
        logic [31:0] r;
        r = c ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
        begin
            r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
        end
        return r;
    endfunction

    function automatic frame_word_t make_word(out_kind_t k, logic [7:0] d, logic rot,
                                              logic [31:0] len, logic [31:0] crc);
        frame_word_t w;
        w.kind = k;
        w.data = d;
        w.rot  = rot;
        w.len  = len;
        w.crc  = crc;
        w.last = 1'b0;
        return w;
    endfunction

    // opens a record when none is open; the size and age check happens only here
    function automatic logic record_open();
        logic rot;
        rot = 1'b0;
        if (rec_open)
            return 1'b0;
        if ((cfg_max_size != 0 && seg_size >= cfg_max_size) ||
            (cfg_max_age != 0 && seg_age >= cfg_max_age))
        begin
            rot      = 1'b1;
            seg_size = '0;
            seg_age  = '0;
        end
        rec_open = 1'b1;
        rec_len  = '0;
        rec_crc  = '1;
        return rot;
    endfunction

    function automatic void record_take(logic [7:0] b);
        rec_crc = crc_step(rec_crc, b);
        rec_len = rec_len + 32'd1;
    endfunction

    // trailer word; the record length, plus framing overhead in framed mode,
    // goes into the segment size, which sticks at its top value
    function automatic frame_word_t record_close();
        frame_word_t w;
        logic [41:0] sum;
        w   = make_word(OUT_TRAILER, 8'd0, 1'b0, rec_len, ~rec_crc);
        sum = {2'b00, seg_size} + {10'd0, rec_len} + (cfg_framed ? 42'd8 : 42'd0);
        seg_size = (sum > {2'b00, SEG_MASK}) ? SEG_MASK : sum[39:0];
        rec_open = 1'b0;
        rec_len  = '0;
        rec_crc  = '1;
        return w;
    endfunction

    // works out the output words caused by one accepted input word
    function automatic void frame_input(in_kind_t k, logic [7:0] d, logic fin);
        frame_word_t run [3];
        int          n;
        logic        rot;
        n = 0;
        case (k)
            KIND_TICK:
            begin
                if (seg_age != '1)
                    seg_age = seg_age + 32'd1;
            end
            KIND_ROTATE:
            begin
                seg_size = '0;
                seg_age  = '0;
                run[n]   = make_word(OUT_ROTATED, 8'd0, 1'b0, 32'd0, 32'd0);
                n++;
            end
            KIND_BYTE:
            begin
                rot = record_open();
                record_take(d);
                run[n] = make_word(OUT_BYTE, d, rot, 32'd0, 32'd0);
                n++;
                if (fin)
                begin
                    if (d != NEWLINE)
                    begin
                        record_take(NEWLINE);
                        run[n] = make_word(OUT_BYTE, NEWLINE, 1'b0, 32'd0, 32'd0);
                        n++;
                    end
                    run[n] = record_close();
                    n++;
                end
            end
            default:
            begin
                // empty record: newline and trailer; rotation check only if no record open
                rot = record_open();
                record_take(NEWLINE);
                run[n] = make_word(OUT_BYTE, NEWLINE, rot, 32'd0, 32'd0);
                n++;
                run[n] = record_close();
                n++;
            end
        endcase
        if (n > 0)
            run[n-1].last = 1'b1;
        for (int i = 0; i < n; i++)
        begin
            words_due = {words_due, run[i]};
        end
    endfunction

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    // data and final flag are don't-care for ticks, rotations and empty
    // records, so those get random values
    function automatic void queue_item(in_kind_t k, logic [7:0] d, logic fin);
        log_item_t it;
        it.kind = k;
        it.data = (k == KIND_BYTE) ? d : 8'($urandom);
        it.fin  = (k == KIND_BYTE) ? fin : 1'($urandom);
        log_items_q = {log_items_q, it};
    endfunction

    // mostly well-formed records, some ticks and rotations, and a little noise
    function automatic void queue_random_items(int count);
        int         made;
        int         sel;
        int         len;
        logic [7:0] b;
        made = 0;
        while (made < count)
        begin
            sel = $urandom_range(99);
            if (sel < 65)
            begin
                len = $urandom_range(1, 6);
                for (int i = 0; i < len; i++)
                begin
                    // a tick or a forced rotation now and then inside a record
                    if (i != 0 && $urandom_range(19) == 0)
                    begin
                        queue_item($urandom_range(1) ? KIND_TICK : KIND_ROTATE, 8'd0, 1'b0);
                        made++;
                    end
                    b = ($urandom_range(3) == 0) ? NEWLINE : 8'($urandom);
                    queue_item(KIND_BYTE, b, i == len - 1);
                    made++;
                end
            end
            else if (sel < 80)
            begin
                len = $urandom_range(1, 3);
                for (int i = 0; i < len; i++)
                begin
                    queue_item(KIND_TICK, 8'd0, 1'b0);
                    made++;
                end
            end
            else if (sel < 87)
            begin
                queue_item(KIND_EMPTY, 8'd0, 1'b0);
                made++;
            end
            else if (sel < 92)
            begin
                queue_item(KIND_ROTATE, 8'd0, 1'b0);
                made++;
            end
            else if (sel < 96)
            begin
                // unterminated record cut short by an empty record
                len = $urandom_range(1, 3);
                for (int i = 0; i < len; i++)
                begin
                    queue_item(KIND_BYTE, 8'($urandom), 1'b0);
                    made++;
                end
                queue_item(KIND_EMPTY, 8'd0, 1'b0);
                made++;
            end
            else
            begin
                queue_item(in_kind_t'($urandom_range(3)), 8'($urandom), 1'($urandom));
                made++;
            end
        end
    endfunction

    task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic set_idling(int src_pct, int sink_pct);
        @(negedge clk);
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
    endtask

    // sender pauses until all words are out and the block has settled
    task automatic wait_idle();
        @(negedge clk);
        while (log_items_q.size() != 0 || s_tvalid || words_due.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic note_failure(string msg);
        if (errors < 10)
            $display("%s", msg);
        errors++;
    endtask

    // ------------------------------------------------------------------------
    // driver: offers the next queued word, holds it until accepted
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= KIND_BYTE;
            s_tlast  <= 1'b0;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (log_items_q.size() != 0 && $urandom_range(99) >= src_idle_pct)
            begin
                drv_item = log_items_q.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= drv_item.kind;
                s_tdata  <= drv_item.data;
                s_tlast  <= drv_item.fin;
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // receiver: random stalls plus one long hold-off counted here
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready        <= 1'b0;
            stall_left      <= 0;
            long_stall_done <= 1'b0;
        end
        else if (stall_left != 0)
        begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (long_stall_req && !long_stall_done)
        begin
            m_tready        <= 1'b0;
            stall_left      <= LONG_STALL;
            long_stall_done <= 1'b1;
        end
        else
        begin
            m_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // monitor: register writes and accepted input words feed the predictor,
    // accepted output words are checked against the oldest expectation
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_we)
            begin
                case (cfg_addr)
                    CFG_FRAMED_MODE: cfg_framed   = cfg_wdata[0];
                    CFG_MAX_BYTES:   cfg_max_size = cfg_wdata[39:0];
                    CFG_MAX_AGE:     cfg_max_age  = cfg_wdata[31:0];
                    default:         ;
                endcase
            end

            if (s_tvalid && s_tready)
                frame_input(in_kind_t'(s_tuser), s_tdata, s_tlast);

            if (m_tvalid && m_tready)
            begin
                if (words_due.size() == 0)
                begin
                    note_failure($sformatf("unexpected word: kind %0d tdata %h last %0b",
                                           m_tuser, m_tdata, m_tlast));
                end
                else
                begin
                    due_word = words_due.pop_front();
                    if (m_tuser !== due_word.kind || m_tdata[7:0] !== due_word.data ||
                        m_tdata[8] !== due_word.rot || m_tdata[40:9] !== due_word.len ||
                        m_tdata[72:41] !== due_word.crc || m_tlast !== due_word.last ||
                        m_tdata[M_TDATA_W-1:M_FIELD_W] !== '0)
                    begin
                        note_failure($sformatf({"mismatch: expected kind %0d byte %02h ",
                            "rot %0b len %0d crc %08h last %0b; got kind %0d byte %02h ",
                            "rot %0b len %0d crc %08h last %0b pad %0h"},
                            due_word.kind, due_word.data, due_word.rot, due_word.len,
                            due_word.crc, due_word.last, m_tuser, m_tdata[7:0],
                            m_tdata[8], m_tdata[40:9], m_tdata[72:41], m_tlast,
                            m_tdata[M_TDATA_W-1:M_FIELD_W]));
                    end
                end
            end

            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles = quiet_cycles + 1;
        end
    end

    // watchdog: nothing moving for too long
    initial
    begin
        @(negedge clk);
        while (quiet_cycles < QUIET_LIMIT)
            @(negedge clk);
        $display("simulation failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed: small limits so both rotation causes fire quickly
        write_reg(CFG_FRAMED_MODE, 40'd1);
        write_reg(CFG_MAX_BYTES, 40'd10);
        write_reg(CFG_MAX_AGE, 40'd2);
        set_idling(0, 0);
        queue_item(KIND_BYTE, 8'h00, 1'b0);     // lowest byte value
        queue_item(KIND_BYTE, 8'hFF, 1'b0);     // highest byte value
        queue_item(KIND_BYTE, 8'h41, 1'b1);     // newline gets appended
        queue_item(KIND_BYTE, NEWLINE, 1'b1);   // already ends in newline
        queue_item(KIND_TICK, 8'd0, 1'b0);
        queue_item(KIND_TICK, 8'd0, 1'b0);
        queue_item(KIND_TICK, 8'd0, 1'b0);
        queue_item(KIND_EMPTY, 8'd0, 1'b0);     // empty record between records
        queue_item(KIND_BYTE, 8'h55, 1'b0);
        queue_item(KIND_EMPTY, 8'd0, 1'b0);     // empty record closes an open one
        queue_item(KIND_BYTE, 8'h12, 1'b0);
        queue_item(KIND_ROTATE, 8'd0, 1'b0);    // forced rotation mid-record
        queue_item(KIND_BYTE, 8'hAA, 1'b0);
        queue_item(KIND_BYTE, NEWLINE, 1'b1);
        queue_item(KIND_ROTATE, 8'd0, 1'b0);    // forced rotation between records
        queue_item(KIND_BYTE, 8'h7F, 1'b1);
        queue_item(KIND_BYTE, 8'h80, 1'b1);     // size limit reached here
        queue_item(KIND_TICK, 8'd0, 1'b0);
        wait_idle();

        // unframed, lowest nonzero limits, sender idling
        write_reg(CFG_FRAMED_MODE, 40'd0);
        write_reg(CFG_MAX_BYTES, 40'd1);
        write_reg(CFG_MAX_AGE, 40'd1);
        set_idling(61, 0);
        queue_random_items(80);
        wait_idle();

        // highest limits; long receiver hold-off while the sender keeps offering
        write_reg(CFG_FRAMED_MODE, 40'd1);
        write_reg(CFG_MAX_BYTES, 40'hFF_FFFF_FFFF);
        write_reg(CFG_MAX_AGE, 40'h00_FFFF_FFFF);
        set_idling(0, 0);
        long_stall_req = 1'b1;
        queue_random_items(40);
        wait_idle();
        set_idling(0, 61);
        queue_random_items(60);
        wait_idle();

        // mid-range limits, both sides idling
        write_reg(CFG_MAX_BYTES, 40'd30);
        write_reg(CFG_MAX_AGE, 40'd4);
        set_idling(61, 61);
        set_idling(32, 32);
        queue_random_items(100);
        wait_idle();

        // limits disabled, no idling
        write_reg(CFG_FRAMED_MODE, 40'd0);
        write_reg(CFG_MAX_BYTES, 40'd0);
        write_reg(CFG_MAX_AGE, 40'd0);
        set_idling(0, 0);
        queue_random_items(80);
        wait_idle();

        if (errors == 0 && words_due.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// File: files.f
rtl/lrf_pkg.sv
rtl/log_record_framer_with_rotation.sv
tb/sv/log_record_framer_with_rotation_tb.sv
